/* sv/ilp5_pkg.sv */
package ilp5_pkg;

   // default widths of the sample and coefficient words
   localparam int DEF_SAMPLE_WIDTH = 16;
   localparam int DEF_COEF_WIDTH   = 32;

   // coefficients are Q5.26 at the default width: six integer bits incl. sign
   localparam int COEF_INT_BITS = 6;

   // fraction bits kept in the output history
   localparam int HIST_FRAC = 8;

   // accumulator wraps modulo 2^ACC_W
   localparam int ACC_W = 64;

   localparam int NUM_TAPS    = 5;
   localparam int NUM_REGS    = 6;
   localparam int CSR_INDEX_W = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FF_GAIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_1    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_2    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_3    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_4    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_5    = 3'd5;

   // binomial numerator weights for the past inputs, newest first
   localparam int TAP_WEIGHT [NUM_TAPS] = '{5, 10, 10, 5, 1};

endpackage

/* sv/ilp5_csr.sv */
module ilp5_csr #(
   parameter int COEF_WIDTH = ilp5_pkg::DEF_COEF_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [ilp5_pkg::CSR_INDEX_W-1:0]     index,
   input  logic [COEF_WIDTH-1:0]                wdata,
   output logic signed [COEF_WIDTH-1:0]         coef [ilp5_pkg::NUM_REGS]
);

   logic signed [COEF_WIDTH-1:0] coef_ff [ilp5_pkg::NUM_REGS];
   logic signed [COEF_WIDTH-1:0] coef_in [ilp5_pkg::NUM_REGS];

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (index)
            ilp5_pkg::REG_FF_GAIN: coef_in[0] = wdata;
            ilp5_pkg::REG_FB_1:    coef_in[1] = wdata;
            ilp5_pkg::REG_FB_2:    coef_in[2] = wdata;
            ilp5_pkg::REG_FB_3:    coef_in[3] = wdata;
            ilp5_pkg::REG_FB_4:    coef_in[4] = wdata;
            ilp5_pkg::REG_FB_5:    coef_in[5] = wdata;
            default:               coef_in = coef_ff;  // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ilp5_pkg::NUM_REGS; i++) coef_ff[i] <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

/* sv/ilp5_datapath.sv */
module ilp5_datapath #(
   parameter int SAMPLE_WIDTH = ilp5_pkg::DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = ilp5_pkg::DEF_COEF_WIDTH
) (
   input  logic signed [SAMPLE_WIDTH-1:0]                     sample,
   input  logic signed [SAMPLE_WIDTH-1:0]                     x_hist [ilp5_pkg::NUM_TAPS],
   input  logic signed [SAMPLE_WIDTH+ilp5_pkg::HIST_FRAC-1:0] y_hist [ilp5_pkg::NUM_TAPS],
   input  logic signed [COEF_WIDTH-1:0]                       coef   [ilp5_pkg::NUM_REGS],
   output logic signed [SAMPLE_WIDTH+ilp5_pkg::HIST_FRAC-1:0] y_new,
   output logic signed [SAMPLE_WIDTH-1:0]                     sample_out
);

   localparam int HW     = SAMPLE_WIDTH + ilp5_pkg::HIST_FRAC;
   localparam int CF     = COEF_WIDTH - ilp5_pkg::COEF_INT_BITS;
   localparam int AW     = ilp5_pkg::ACC_W;
   localparam int XSUM_W = SAMPLE_WIDTH + 5;

   localparam logic signed [AW-1:0] Y_ROUND = AW'(1) <<< (CF - 1);
   localparam logic signed [AW-1:0] Y_MAX   = (AW'(1) <<< (HW - 1)) - AW'(1);
   localparam logic signed [AW-1:0] Y_MIN   = -Y_MAX - AW'(1);
   localparam logic signed [HW:0]   O_ROUND = (HW+1)'(1) <<< (ilp5_pkg::HIST_FRAC - 1);
   localparam logic signed [HW:0]   O_MAX   = ((HW+1)'(1) <<< (SAMPLE_WIDTH - 1)) - (HW+1)'(1);
   localparam logic signed [HW:0]   O_MIN   = -O_MAX - (HW+1)'(1);

   logic signed [XSUM_W-1:0] xsum;
   logic signed [AW-1:0]     ff_prod;
   logic signed [AW-1:0]     fb_sum;
   logic signed [AW-1:0]     acc;
   logic signed [AW-1:0]     y_scaled;
   logic signed [HW:0]       o_wide;
   logic signed [HW:0]       o_shift;

   always_comb begin
      // binomial sum of the inputs, exact in XSUM_W bits
      xsum = XSUM_W'(sample);
      for (int i = 0; i < ilp5_pkg::NUM_TAPS; i++) begin
         xsum = xsum + XSUM_W'(x_hist[i]) * XSUM_W'(ilp5_pkg::TAP_WEIGHT[i]);
      end

      ff_prod = AW'(coef[0]) * AW'(xsum);

      fb_sum = '0;
      for (int i = 0; i < ilp5_pkg::NUM_TAPS; i++) begin
         fb_sum = fb_sum + AW'(coef[i+1]) * AW'(y_hist[i]);
      end

      acc      = (ff_prod <<< ilp5_pkg::HIST_FRAC) - fb_sum + Y_ROUND;
      y_scaled = acc >>> CF;

      if (y_scaled > Y_MAX) begin
         y_new = Y_MAX[HW-1:0];
      end else if (y_scaled < Y_MIN) begin
         y_new = Y_MIN[HW-1:0];
      end else begin
         y_new = y_scaled[HW-1:0];
      end

      // round the history value to an integer sample
      o_wide  = (HW+1)'(y_new) + O_ROUND;
      o_shift = o_wide >>> ilp5_pkg::HIST_FRAC;

      if (o_shift > O_MAX) begin
         sample_out = O_MAX[SAMPLE_WIDTH-1:0];
      end else if (o_shift < O_MIN) begin
         sample_out = O_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         sample_out = o_shift[SAMPLE_WIDTH-1:0];
      end
   end

endmodule

/* sv/iir_lowpass_order5.sv */
// Fifth-order direct-form-I IIR lowpass with a binomial numerator.
//
// Input stream req_*: one signed sample per word in req_tdata.
// Output stream rsp_*: one filtered, rounded and saturated sample per word.
// Configuration csr_*: write csr_wdata into register csr_index when
// csr_wr_en is high (0 gain, 1..5 feedback, newest output first); indexes
// beyond the list are dropped. Write only while no word is in flight.
//
// A word taken sits in the input register; when it advances, the result
// register is loaded and rsp_tvalid rises; the word leaves from there once
// rsp_tready is high. Throughput: one word per cycle while rsp_tready stays
// high. The recursion through the output history closes in one pass of the
// datapath: eleven products and their sum lie between the input register
// and the result register and history.
//
// Reset clears the coefficients, both histories and both valid flags.
// When the receiver stalls, the result register holds its word and the input
// register takes one more; req_tready then falls until rsp_tready returns.
module iir_lowpass_order5 #(
   parameter int SAMPLE_WIDTH = ilp5_pkg::DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = ilp5_pkg::DEF_COEF_WIDTH,
   parameter int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [DATA_W-1:0]                req_tdata,   // sample_in
   // output stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [DATA_W-1:0]                rsp_tdata,   // sample_out
   // configuration writes
   input  logic                             csr_wr_en,
   input  logic [ilp5_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]            csr_wdata
);

   localparam int HW = SAMPLE_WIDTH + ilp5_pkg::HIST_FRAC;

   logic signed [COEF_WIDTH-1:0] coef [ilp5_pkg::NUM_REGS];

   // input register
   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff, in_sample_in;

   // result register
   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_WIDTH-1:0] out_sample_ff, out_sample_in;

   // filter state, newest first
   logic signed [SAMPLE_WIDTH-1:0] xh_ff [ilp5_pkg::NUM_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] xh_in [ilp5_pkg::NUM_TAPS];
   logic signed [HW-1:0]           yh_ff [ilp5_pkg::NUM_TAPS];
   logic signed [HW-1:0]           yh_in [ilp5_pkg::NUM_TAPS];

   logic signed [HW-1:0]           y_new;
   logic signed [SAMPLE_WIDTH-1:0] y_sample;
   logic                           advance;
   logic                           req_take;

   ilp5_csr #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .coef  (coef)
   );

   ilp5_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_datapath (
      .sample     (in_sample_ff),
      .x_hist     (xh_ff),
      .y_hist     (yh_ff),
      .coef       (coef),
      .y_new      (y_new),
      .sample_out (y_sample)
   );

   // advance the held word when the result register is free or being emptied
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_sample_in  = in_sample_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      xh_in         = xh_ff;
      yh_in         = yh_ff;

      // drop the result once taken; a new one may replace it in the same cycle
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in   = 1'b0;
         out_valid_in  = 1'b1;
         out_sample_in = y_sample;
         for (int i = ilp5_pkg::NUM_TAPS - 1; i > 0; i--) begin
            xh_in[i] = xh_ff[i-1];
            yh_in[i] = yh_ff[i-1];
         end
         xh_in[0] = in_sample_ff;
         yh_in[0] = y_new;
      end

      // take the next word; upper padding bits of tdata are ignored
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_tdata[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < ilp5_pkg::NUM_TAPS; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         xh_ff        <= xh_in;
         yh_ff        <= yh_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      in_sample_ff  <= in_sample_in;
      out_sample_ff <= out_sample_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_W'(out_sample_ff);

`ifndef NO_ASSERTIONS
   // back-pressure only while a word sits in the input register
   a_ready_low_needs_word: assert property (
      @(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready)
   ) else $error("req_tready low without a stalled word");

   // a word that cannot advance stays in the input register unchanged
   a_input_word_held: assert property (
      @(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_sample_ff))
   ) else $error("input word lost while stalled");

   // history shifts by one place on each processed word
   a_history_shift: assert property (
      @(posedge clock) disable iff (reset)
      advance |=> (xh_ff[1] == $past(xh_ff[0]) && yh_ff[1] == $past(yh_ff[0]))
   ) else $error("history did not shift");

   // history is untouched when no word is processed
   a_history_hold: assert property (
      @(posedge clock) disable iff (reset)
      !advance |=> ($stable(xh_ff[0]) && $stable(yh_ff[0]))
   ) else $error("history changed without a word");
`endif

endmodule
